[hdl/lcp_pkg.sv]
package lcp_pkg;

  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegClusterDistance = 1'b0;
  localparam int unsigned ThrW = 16;
  localparam int unsigned LabelW = 6;
  localparam int unsigned FieldW = 16;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DECIDE  = 6'b000100,
    S_DIV     = 6'b001000,
    S_OUT     = 6'b010000,
    S_RESTORE = 6'b100000
  } state_t;

endpackage

[hdl/lcp_cell.sv]
module lcp_cell #(
  parameter int CW = 16,
  parameter int NW = 16
) (
  input  logic          clk,
  input  logic          load,
  input  logic          shift,
  input  logic [CW-1:0] in_x,
  input  logic [CW-1:0] in_y,
  input  logic [NW-1:0] in_n,
  output logic [CW-1:0] x,
  output logic [CW-1:0] y,
  output logic [NW-1:0] n
);

  // Take the neighbor's entry on a rotate step, or a direct write.
  always_ff @(posedge clk) begin
    if (shift || load) begin
      x <= in_x;
      y <= in_y;
      n <= in_n;
    end
  end

endmodule

[hdl/lcp_div.sv]
module lcp_div #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic [W-1:0] quo
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] q;
  logic [W-1:0] d;
  logic [CntW-1:0] cnt;
  logic [W:0] trial;

  assign trial = {rem, q[W-1]};
  assign quo = q;

  // Restoring division, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CntW'(W);
      rem <= '0;
      q <= num;
      d <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= W'(trial - {1'b0, d});
        q <= {q[W-2:0], 1'b1};
      end else begin
        rem <= trial[W-1:0];
        q <= {q[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

endmodule

[hdl/leader_clustering_2d_points_core.sv]
// Result path: a point is scanned against the table, then the chosen entry is rotated to the head; a
// join also runs the shared bit-serial divider (x, then y), W = max(COORD_WIDTH, COUNT_WIDTH) + 2 bits wide.
// Throughput: one point in flight; the next accept waits until entry 0 is rotated back to the head.
// Reset: rst is synchronous; it empties the table and clears cluster_distance.
module leader_clustering_2d_points_core #(
  parameter int MAX_CLUSTERS = 64,
  parameter int COORD_WIDTH  = 16,
  parameter int COUNT_WIDTH  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcp_pkg::CfgAddrW+1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       valid_in,
  output logic                       ready_in,
  input  logic [COORD_WIDTH-1:0]     point_x,
  input  logic [COORD_WIDTH-1:0]     point_y,
  input  logic                       first_of_set,
  output logic                       valid_out,
  input  logic                       ready_out,
  output logic [lcp_pkg::LabelW-1:0] cluster_label,
  output logic                       new_cluster,
  output logic                       table_full,
  output logic [lcp_pkg::FieldW-1:0] mean_x,
  output logic [lcp_pkg::FieldW-1:0] mean_y,
  output logic [lcp_pkg::FieldW-1:0] member_count
);

  localparam int N    = MAX_CLUSTERS;
  localparam int IW   = $clog2(N);
  localparam int UW   = $clog2(N + 1);
  localparam int CW   = COORD_WIDTH;
  localparam int NW   = COUNT_WIDTH;
  localparam int SW   = 2 * CW + 1;
  localparam int DW   = (CW > NW ? CW : NW) + 2;
  localparam logic [NW-1:0] CountMax = {NW{1'b1}};

  // Configuration
  logic [lcp_pkg::ThrW-1:0] cluster_distance;
  logic [2*lcp_pkg::ThrW-1:0] thr2;
  assign pready = 1'b1;
  assign prdata = 32'(cluster_distance);
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_distance <= '0;
    end else if (psel && penable && pwrite &&
                 paddr[lcp_pkg::CfgAddrW+1:2] == lcp_pkg::RegClusterDistance) begin
      cluster_distance <= pwdata[lcp_pkg::ThrW-1:0];
    end
  end
  always_ff @(posedge clk) thr2 <= cluster_distance * cluster_distance;

  lcp_pkg::state_t state;
  logic [UW-1:0] used;
  logic [UW-1:0] step;
  logic [CW-1:0] px, py;
  logic [IW-1:0] label;
  logic found;
  logic [SW-1:0] best;
  logic join_d, open_d, full_d;
  logic phase_y;
  logic [CW-1:0] new_x;
  logic sub_pending;
  logic decided;

  // Chain of cells; cell 0 is the head, the tail feeds back to the head.
  logic [CW-1:0] cx [N];
  logic [CW-1:0] cy [N];
  logic [NW-1:0] cn [N];
  logic [CW-1:0] ix [N];
  logic [CW-1:0] iy [N];
  logic [NW-1:0] in_n [N];
  logic rot, wr_head;
  logic [CW-1:0] wx, wy;
  logic [NW-1:0] wn;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign ix[i] = wr_head ? wx : cx[N-1];
      assign iy[i] = wr_head ? wy : cy[N-1];
      assign in_n[i] = wr_head ? wn : cn[N-1];
    end else begin : g_body
      assign ix[i] = cx[i-1];
      assign iy[i] = cy[i-1];
      assign in_n[i] = cn[i-1];
    end
    lcp_cell #(.CW(CW), .NW(NW)) u_cell (
      .clk(clk), .load(wr_head && i == 0), .shift(rot),
      .in_x(ix[i]), .in_y(iy[i]), .in_n(in_n[i]),
      .x(cx[i]), .y(cy[i]), .n(cn[i])
    );
  end

  // Distance at the head cell; the head holds entry index step.
  logic [CW-1:0] dx, dy;
  logic [2*CW-1:0] sqx, sqy;
  logic [SW-1:0] dsq;
  logic [IW-1:0] sidx;
  logic svalid;
  always_ff @(posedge clk) begin
    sqx <= dx * dx;
    sqy <= dy * dy;
  end
  assign dx = px > cx[0] ? px - cx[0] : cx[0] - px;
  assign dy = py > cy[0] ? py - cy[0] : cy[0] - py;
  assign dsq = SW'(sqx) + SW'(sqy);

  // Divider for the running mean.
  logic div_start, div_busy;
  logic [DW-1:0] div_num, div_den, div_q;
  lcp_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_q)
  );

  // Mean step operands for the head cell's entry, with n the old count.
  logic [CW-1:0] m_cur, p_cur;
  logic [DW-1:0] den, half, mag;
  logic up, dn_sub;
  assign m_cur = phase_y ? cy[0] : cx[0];
  assign p_cur = phase_y ? py : px;
  assign den = DW'(cn[0]) + 1'b1;
  assign half = den >> 1;
  assign up = p_cur >= m_cur;
  assign mag = up ? DW'(p_cur - m_cur) : DW'(m_cur - p_cur);
  assign dn_sub = !up && half < mag;
  always_comb begin
    if (up) div_num = mag + half;
    else if (!dn_sub) div_num = half - mag;
    else div_num = mag - half + den - 1'b1;
  end
  assign div_den = den;
  logic sub_r;
  logic [CW-1:0] stepped;
  assign stepped = sub_r ? CW'(m_cur - CW'(div_q)) : CW'(m_cur + CW'(div_q));

  logic done_div;
  logic dv_q;
  always_ff @(posedge clk) dv_q <= div_busy;
  assign done_div = dv_q && !div_busy;

  assign ready_in = state == lcp_pkg::S_IDLE;

  always_comb begin
    rot = 1'b0;
    wr_head = 1'b0;
    wx = px;
    wy = py;
    wn = NW'(1);
    div_start = 1'b0;
    case (state)
      lcp_pkg::S_SCAN: rot = step < UW'(N);
      lcp_pkg::S_DECIDE: rot = decided && IW'(step) != label;
      lcp_pkg::S_DIV: begin
        div_start = !div_busy && !dv_q && !sub_pending;
        if (done_div && phase_y) begin
          wr_head = 1'b1;
          wx = new_x;
          wy = stepped;
          wn = cn[0] < CountMax ? cn[0] + 1'b1 : cn[0];
        end
      end
      // store the opened entry at the head
      lcp_pkg::S_OUT: wr_head = !valid_out && open_d;
      // rotate entry 0 back to the head
      lcp_pkg::S_RESTORE: rot = step != '0 && step != UW'(N);
      default: ;
    endcase
  end

  // Sequencer: scan the rotation, bring the chosen entry to the head, update and output, then rotate back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcp_pkg::S_IDLE;
      used <= '0;
      valid_out <= 1'b0;
      sub_pending <= 1'b0;
    end else begin
      case (state)
        lcp_pkg::S_IDLE: begin
          if (valid_in) begin
            px <= point_x;
            py <= point_y;
            if (first_of_set) used <= '0;
            step <= '0;
            found <= 1'b0;
            svalid <= 1'b0;
            state <= lcp_pkg::S_SCAN;
          end
        end
        lcp_pkg::S_SCAN: begin
          // head holds entry step; result of previous head lands now
          svalid <= step < used;
          sidx <= IW'(step);
          if (svalid && (!found || dsq < best)) begin
            found <= 1'b1;
            best <= dsq;
            label <= sidx;
          end
          if (step < UW'(N)) step <= step + 1'b1;
          else begin
            join_d <= 1'b0;
            open_d <= 1'b0;
            full_d <= 1'b0;
            decided <= 1'b0;
            step <= '0;
            state <= lcp_pkg::S_DECIDE;
          end
        end
        lcp_pkg::S_DECIDE: begin
          if (!decided) begin
            decided <= 1'b1;
            if (found && best < SW'(thr2)) join_d <= 1'b1;
            else if (used < UW'(N)) begin
              open_d <= 1'b1;
              label <= IW'(used);
            end else full_d <= 1'b1;
          end
          // rotate until the labelled entry sits at the head
          if (decided) begin
            if (IW'(step) == label) begin
              if (join_d) begin
                phase_y <= 1'b0;
                sub_pending <= 1'b0;
                state <= lcp_pkg::S_DIV;
              end else state <= lcp_pkg::S_OUT;
            end else step <= step + 1'b1;
          end
        end
        lcp_pkg::S_DIV: begin
          if (div_start) sub_r <= dn_sub;
          if (div_start) sub_pending <= 1'b1;
          if (done_div) begin
            sub_pending <= 1'b0;
            if (!phase_y) begin
              new_x <= stepped;
              phase_y <= 1'b1;
            end else state <= lcp_pkg::S_OUT;
          end
        end
        lcp_pkg::S_OUT: begin
          if (!valid_out) begin
            if (open_d) begin
              used <= used + 1'b1;
            end
            cluster_label <= lcp_pkg::LabelW'(label);
            new_cluster <= open_d;
            table_full <= full_d;
            mean_x <= lcp_pkg::FieldW'(open_d ? px : cx[0]);
            mean_y <= lcp_pkg::FieldW'(open_d ? py : cy[0]);
            member_count <= lcp_pkg::FieldW'(open_d ? NW'(1) : cn[0]);
            valid_out <= 1'b1;
          end else if (ready_out) begin
            valid_out <= 1'b0;
            state <= lcp_pkg::S_RESTORE;
          end
        end
        lcp_pkg::S_RESTORE: begin
          if (step == '0 || step == UW'(N)) state <= lcp_pkg::S_IDLE;
          else step <= step + 1'b1;
        end
        default: state <= lcp_pkg::S_IDLE;
      endcase
    end
  end

  // Hold the result beat until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    valid_out && !ready_out |=> valid_out && $stable(cluster_label) &&
      $stable(new_cluster) && $stable(table_full) && $stable(mean_x) &&
      $stable(mean_y) && $stable(member_count));
  // Take no input while a result is pending.
  assert property (@(posedge clk) disable iff (rst) ready_in |-> !valid_out);
  // Keep the sequencer one-hot.
  assert property (@(posedge clk) disable iff (rst) $onehot(state));
  // Keep the fill count within the table.
  assert property (@(posedge clk) disable iff (rst) used <= UW'(N));

endmodule
